/* rtl/erg_pkg.sv */
// ----------------------------------------------------------------------------
// Euclidean rhythm generator package
// Shared payload types, controller states and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package erg_pkg;

  // Fixed field widths of the request and result beats.
  localparam int STEP_W = 5;
  localparam int POS_W  = 4;

  // Request beat: pattern length and number of pulses.
  typedef struct packed {
    logic [STEP_W-1:0] step_count;
    logic [STEP_W-1:0] beat_count;
  } erg_req_t;

  // Result beat: one step of the pattern.
  typedef struct packed {
    logic             pulse;
    logic [POS_W-1:0] position;
    logic             last;
  } erg_rsp_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_EXPAND
  } erg_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // latch a new request
    logic div_start;   // start one Euclid division
    logic div_commit;  // store quotient and remainder, advance level
    logic div_finish;  // store final level and seed the expansion stack
    logic expand;      // perform one expansion step
  } erg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_empty;   // the pending request has zero steps
    logic div_more;    // another division level is needed
    logic div_done;    // the divider has a result
    logic stack_empty; // expansion is complete
    logic step_emits;  // the next expansion step produces a result
    logic out_free;    // the output register can take a result
  } erg_status_t;

endpackage

/* rtl/erg_if.sv */
// ----------------------------------------------------------------------------
// Euclidean rhythm generator channels
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface erg_req_if import erg_pkg::*; ();
  logic     valid;
  logic     ready;
  erg_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface erg_rsp_if import erg_pkg::*; ();
  logic     valid;
  logic     ready;
  erg_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/euclidean_rhythm_generator.sv */
// Flow: after a request beat is taken, the controller checks each level and runs
// one Euclid division per level that needs one, then performs one expansion step
// per cycle, with a result beat registered on each step that emits one; a step
// that emits waits while the output register is full. One request at a time.
// Reset: synchronous, active high; clears the controller, stack and result valid.
// ----------------------------------------------------------------------------
// Euclidean rhythm generator
// Builds a Bjorklund rhythm from a step and beat count and streams one result
// beat per step, marking the final one.
// ----------------------------------------------------------------------------
module euclidean_rhythm_generator import erg_pkg::*; #(
  parameter int MAX_STEPS  = 16,
  parameter int MAX_LEVELS = 16
) (
  input logic       clk,
  input logic       rst,
  erg_req_if.sink   req,
  erg_rsp_if.source rsp
);

  erg_cmd_t    cmd;
  erg_status_t st;
  logic        req_ready;
  logic        rsp_valid;
  erg_rsp_t    rsp_data;

  // Sequencer.
  erg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Tables, divider, stack and output register.
  erg_dp #(
    .MAX_STEPS  (MAX_STEPS),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .req_data  (req.payload),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp_valid),
    .rsp_data  (rsp_data)
  );

  // Channel hookup.
  assign req.ready   = req_ready;
  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_data;

endmodule

/* rtl/erg_div.sv */
// ----------------------------------------------------------------------------
// Euclidean rhythm generator divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module erg_div #(
  parameter int W = 5
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  q;
  logic [W-1:0]  r;
  logic [W-1:0]  b;
  logic [W:0]    r_sh;
  logic [W:0]    diff;
  logic          ge;

  // Shift in the next dividend bit and trial-subtract the divisor.
  always_comb begin
    r_sh = {r, q[W-1]};
    diff = r_sh - {1'b0, b};
    ge   = (r_sh >= {1'b0, b});
  end

  // Control: busy flag, bit counter and the done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      b <= divisor;
    end else if (busy) begin
      q <= {q[W-2:0], ge};
      r <= ge ? diff[W-1:0] : r_sh[W-1:0];
    end
  end

  assign quot = q;
  assign rem  = r;

endmodule

/* rtl/erg_dp.sv */
// ----------------------------------------------------------------------------
// Euclidean rhythm generator datapath
// Level tables, Euclid division, expansion stack and the result register.
// ----------------------------------------------------------------------------
module erg_dp import erg_pkg::*; #(
  parameter int MAX_STEPS  = 16,
  parameter int MAX_LEVELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  erg_cmd_t    cmd,
  output erg_status_t st,
  input  erg_req_t    req_data,
  input  logic        rsp_ready,
  output logic        rsp_valid,
  output erg_rsp_t    rsp_data
);

  localparam int W   = $clog2(MAX_STEPS + 1);
  localparam int LW  = $clog2(MAX_LEVELS);
  localparam int SPW = $clog2(MAX_LEVELS + 1);

  // Per-level tables and the expansion stack.
  logic [W-1:0]   level_counts     [MAX_LEVELS];
  logic [W-1:0]   level_remainders [MAX_LEVELS];
  logic [LW-1:0]  stack_level      [MAX_LEVELS];
  logic [W-1:0]   stack_iter       [MAX_LEVELS];
  logic [SPW-1:0] stack_top;

  // Request and division state.
  logic [W-1:0]  steps;
  logic [W-1:0]  running_divisor;
  logic [W-1:0]  rem_cur;
  logic [LW-1:0] lvl;
  logic [W-1:0]  emit_index;

  // Request decode.
  logic [W-1:0] steps_in;
  logic [W-1:0] beats_in;

  // Expansion step decode.
  logic [SPW-1:0] top_m1;
  logic [LW-1:0]  top_idx;
  logic [LW-1:0]  cur;
  logic [W-1:0]   it;
  logic [W-1:0]   cnt;
  logic [W-1:0]   rm;
  logic           rep;
  logic           step_emits;
  logic           emit_bit;
  logic           push_child;
  logic           replace_top;
  logic           emit;

  // Divider.
  logic         div_done;
  logic [W-1:0] div_quot;
  logic [W-1:0] div_rem;

  erg_div #(.W(W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (running_divisor),
    .divisor  (rem_cur),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Saturate the step count and clamp the beat count to it.
  always_comb begin
    if (int'(req_data.step_count) > MAX_STEPS) begin
      steps_in = W'(MAX_STEPS);
    end else begin
      steps_in = W'(req_data.step_count);
    end
    if (int'(req_data.beat_count) > int'(steps_in)) begin
      beats_in = steps_in;
    end else begin
      beats_in = W'(req_data.beat_count);
    end
  end

  // Decode the top stack frame. A child at level -1 is a rest and at level -2
  // a pulse; deeper children are pushed as new frames or replace the finished top frame.
  always_comb begin
    top_m1      = stack_top - SPW'(1);
    top_idx     = top_m1[LW-1:0];
    cur         = stack_level[top_idx];
    it          = stack_iter[top_idx];
    cnt         = level_counts[cur];
    rm          = level_remainders[cur];
    rep         = (it < cnt);
    step_emits  = rep ? (cur == '0) : ((rm != '0) && (cur <= LW'(1)));
    emit_bit    = !rep && (cur == '0);
    push_child  = rep && (cur != '0) && (stack_top < SPW'(MAX_LEVELS));
    replace_top = !rep && (rm != '0) && (cur > LW'(1));
    emit        = cmd.expand && step_emits;
  end

  // Status toward the controller.
  always_comb begin
    st.req_empty   = (steps_in == '0);
    st.div_more    = (rem_cur > W'(1)) && (lvl != LW'(MAX_LEVELS - 1));
    st.div_done    = div_done;
    st.stack_empty = (stack_top == '0);
    st.step_emits  = step_emits;
    st.out_free    = !rsp_valid || rsp_ready;
  end

  // Request, division and table registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      steps           <= steps_in;
      running_divisor <= steps_in - beats_in;
      rem_cur         <= beats_in;
      lvl             <= '0;
    end
    if (cmd.div_commit) begin
      level_counts[lvl]     <= div_quot;
      level_remainders[lvl] <= rem_cur;
      rem_cur               <= div_rem;
      running_divisor       <= rem_cur;
      lvl                   <= lvl + LW'(1);
    end
    if (cmd.div_finish) begin
      level_counts[lvl]     <= running_divisor;
      level_remainders[lvl] <= rem_cur;
      stack_level[0]        <= lvl;
      stack_iter[0]         <= '0;
    end
    if (cmd.expand) begin
      if (rep) begin
        stack_iter[top_idx] <= it + W'(1);
      end
      if (push_child) begin
        stack_level[stack_top[LW-1:0]] <= cur - LW'(1);
        stack_iter[stack_top[LW-1:0]]  <= '0;
      end
      if (replace_top) begin
        stack_level[top_idx] <= cur - LW'(2);
        stack_iter[top_idx]  <= '0;
      end
    end
    if (emit) begin
      rsp_data.pulse    <= emit_bit;
      rsp_data.position <= POS_W'(emit_index);
      rsp_data.last     <= (emit_index == steps - W'(1));
    end
  end

  // Stack pointer, emit counter and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_top  <= '0;
      emit_index <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        stack_top  <= '0;
        emit_index <= '0;
      end else if (cmd.div_finish) begin
        stack_top <= SPW'(1);
      end else if (cmd.expand) begin
        if (push_child) begin
          stack_top <= stack_top + SPW'(1);
        end else if (!rep && !replace_top) begin
          stack_top <= top_m1;
        end
      end
      if (emit) begin
        emit_index <= emit_index + W'(1);
        rsp_valid  <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // A result is only produced when the output register can take it.
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> st.out_free)
    else $error("result produced while output register is occupied");

  // The expansion stack never grows past its depth.
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_top <= SPW'(MAX_LEVELS))
    else $error("expansion stack overflow");

  // A finished divide is followed by a commit on the same cycle.
  a_div_commit: assert property (@(posedge clk) disable iff (rst)
    div_done |-> cmd.div_commit)
    else $error("divider result not consumed");

endmodule

/* rtl/erg_ctrl.sv */
// ----------------------------------------------------------------------------
// Euclidean rhythm generator controller
// Sequences request load, Euclid divisions and pattern expansion.
// ----------------------------------------------------------------------------
module erg_ctrl import erg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  erg_status_t st,
  output erg_cmd_t    cmd
);

  erg_state_t state;
  erg_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = st.req_empty ? ST_IDLE : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (st.div_more) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIVIDE;
        end else begin
          cmd.div_finish = 1'b1;
          state_next     = ST_EXPAND;
        end
      end
      ST_DIVIDE: begin
        if (st.div_done) begin
          cmd.div_commit = 1'b1;
          state_next     = ST_CHECK;
        end
      end
      ST_EXPAND: begin
        if (st.stack_empty) begin
          state_next = ST_IDLE;
        end else if (!st.step_emits || st.out_free) begin
          cmd.expand = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // The divider only reports a result while a divide is under way.
  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    st.div_done |-> state == ST_DIVIDE)
    else $error("divider done outside divide state");

  // Between requests the expansion stack is empty.
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> st.stack_empty)
    else $error("stack not empty while idle");

  // A request is taken only from idle, and then work starts or ends at once.
  a_load_next: assert property (@(posedge clk) disable iff (rst)
    cmd.load && !st.req_empty |=> state == ST_CHECK)
    else $error("request load did not start division");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euclidean rhythm generator testbench
// Sends step and beat count requests through the request channel and checks
// every result beat against an in-bench rhythm builder. The builder runs
// Euclid's division on the clamped counts and expands the levels with an
// explicit stack. Both channels idle and stall at random, with stretches
// run back to back.
// ----------------------------------------------------------------------------
module testbench;
  import erg_pkg::*;

  localparam int STEP_LIMIT  = 16;
  localparam int LEVEL_LIMIT = 16;
  localparam int WATCHDOG    = 4000;
  localparam int DRAIN_WAIT  = 64;

  logic clk;
  logic rst;

  erg_req_if req_if ();
  erg_rsp_if rsp_if ();

  euclidean_rhythm_generator u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // Expected result beats, oldest first.
  erg_rsp_t pending_steps [$];
  int       mismatch_count = 0;
  int       quiet_cycles = 0;
  int       stall_left = 0;
  bit       steady;

  // Clock with a 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Gap length: mostly none or short, a few long. No gaps in steady stretches.
  function automatic int pick_gap();
    int roll;
    if (steady) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Build the whole rhythm for one request and queue its result beats.
  function automatic void predict_rhythm(input logic [4:0] step_field,
                                         input logic [4:0] beat_field);
    int       steps;
    int       beats;
    int       lvl;
    int       divisor;
    int       top;
    int       emitted;
    int       cur;
    int       next_lvl;
    bit       has_next;
    int       counts [LEVEL_LIMIT];
    int       rems [LEVEL_LIMIT + 1];
    int       frame_lvl [LEVEL_LIMIT];
    int       frame_iter [LEVEL_LIMIT];
    erg_rsp_t rhythm [$];
    erg_rsp_t step_rsp;

    steps = int'(step_field);
    beats = int'(beat_field);
    if (steps > STEP_LIMIT) begin
      steps = STEP_LIMIT;
    end
    if (beats > steps) begin
      beats = steps;
    end
    if (steps == 0) begin
      return;
    end

    // Euclid's division fills the count and remainder tables.
    divisor = steps - beats;
    rems[0] = beats;
    lvl = 0;
    while (rems[lvl] > 1 && lvl < LEVEL_LIMIT - 1) begin
      counts[lvl]   = divisor / rems[lvl];
      rems[lvl + 1] = divisor % rems[lvl];
      divisor       = rems[lvl];
      lvl++;
    end
    counts[lvl] = divisor;

    // Expand from the top level; level -1 is a rest and level -2 a pulse.
    top      = 0;
    emitted  = 0;
    has_next = 1'b1;
    next_lvl = lvl;
    forever begin
      if (has_next) begin
        has_next = 1'b0;
        if (next_lvl < 0) begin
          if (emitted < STEP_LIMIT) begin
            step_rsp.pulse    = (next_lvl == -2);
            step_rsp.position = emitted[POS_W-1:0];
            step_rsp.last     = 1'b0;
            rhythm = {rhythm, step_rsp};
            emitted++;
          end
        end else if (top < LEVEL_LIMIT) begin
          frame_lvl[top]  = next_lvl;
          frame_iter[top] = 0;
          top++;
        end
      end else if (top == 0) begin
        break;
      end else begin
        cur = frame_lvl[top - 1];
        if (frame_iter[top - 1] < counts[cur]) begin
          frame_iter[top - 1]++;
          next_lvl = cur - 1;
          has_next = 1'b1;
        end else begin
          top--;
          if (rems[cur] != 0) begin
            next_lvl = cur - 2;
            has_next = 1'b1;
          end
        end
      end
    end

    if (rhythm.size() > 0) begin
      rhythm[rhythm.size() - 1].last = 1'b1;
    end
    pending_steps = {pending_steps, rhythm};
  endfunction

  // Send one request beat and record its expected rhythm once accepted.
  task automatic send_pattern(input logic [4:0] step_field, input logic [4:0] beat_field);
    int       gap;
    erg_req_t item;
    gap = pick_gap();
    item.step_count = step_field;
    item.beat_count = beat_field;
    repeat (gap) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
    end
    @(negedge clk);
    req_if.valid   <= 1'b1;
    req_if.payload <= item;
    @(posedge clk);
    while (!req_if.ready) begin
      @(posedge clk);
    end
    predict_rhythm(step_field, beat_field);
  endtask

  // A random request: mostly in range, with some out-of-range counts.
  task automatic send_random_pattern(input bit allow_wild);
    logic [4:0] steps;
    logic [4:0] beats;
    if (allow_wild && $urandom_range(0, 7) == 0) begin
      steps = 5'($urandom_range(0, 31));
      beats = 5'($urandom_range(0, 31));
    end else begin
      steps = 5'($urandom_range(1, STEP_LIMIT));
      beats = 5'($urandom_range(0, steps));
    end
    send_pattern(steps, beats);
  endtask

  // Corner counts: zero and one step, zero and one beat, full, clamped, saturated.
  task automatic test_corner_counts();
    send_pattern(5'd1, 5'd0);
    send_pattern(5'd1, 5'd1);
    send_pattern(5'd0, 5'd0);
    send_pattern(5'd0, 5'd7);
    send_pattern(5'd16, 5'd0);
    send_pattern(5'd16, 5'd1);
    send_pattern(5'd16, 5'd15);
    send_pattern(5'd16, 5'd16);
    send_pattern(5'd5, 5'd31);
    send_pattern(5'd31, 5'd0);
    send_pattern(5'd31, 5'd31);
    send_pattern(5'd17, 5'd9);
    send_pattern(5'd2, 5'd1);
  endtask

  // Well-known rhythms that take several division levels.
  task automatic test_known_rhythms();
    send_pattern(5'd8, 5'd3);
    send_pattern(5'd8, 5'd5);
    send_pattern(5'd12, 5'd5);
    send_pattern(5'd13, 5'd5);
    send_pattern(5'd16, 5'd9);
    send_pattern(5'd16, 5'd7);
    send_pattern(5'd7, 5'd4);
    send_pattern(5'd9, 5'd2);
    send_pattern(5'd11, 5'd8);
    send_pattern(5'd15, 5'd6);
  endtask

  // Random requests with idling on both channels.
  task automatic test_random_paced();
    repeat (150) begin
      send_random_pattern(1'b1);
    end
  endtask

  // Random requests with both channels held busy.
  task automatic test_random_back_to_back();
    steady = 1'b1;
    repeat (40) begin
      send_random_pattern(1'b0);
    end
    steady = 1'b0;
  endtask

  // Result side: ready runs high with random stall stretches.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      rsp_if.ready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
    end
  end

  // Report one field mismatch.
  function automatic void note_mismatch(input string field, input int expected_val,
                                        input int actual_val);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d",
             $time, field, expected_val, actual_val);
  endfunction

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin : check_steps
    erg_rsp_t want;
    erg_rsp_t got;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.payload;
      if (pending_steps.size() == 0) begin
        note_mismatch("unexpected beat (position)", -1, got.position);
      end else begin
        want = pending_steps.pop_front();
        if (got.pulse !== want.pulse) begin
          note_mismatch("pulse", want.pulse, got.pulse);
        end
        if (got.position !== want.position) begin
          note_mismatch("position", want.position, got.position);
        end
        if (got.last !== want.last) begin
          note_mismatch("last", want.last, got.last);
        end
      end
    end
  end

  // Watchdog: end the run after too many cycles with no beat accepted.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG) begin
      $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    rst            = 1'b1;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    steady         = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_corner_counts();
    test_known_rhythms();
    test_random_paced();
    test_random_back_to_back();

    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_steps.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* euclidean_rhythm_generator.f */
rtl/erg_pkg.sv
rtl/erg_if.sv
rtl/erg_div.sv
rtl/erg_dp.sv
rtl/erg_ctrl.sv
rtl/euclidean_rhythm_generator.sv
tb/testbench.sv
